>>> hw/rtl/ate_pkg.sv
// Shared types and codes for the array table engine.
`default_nettype none
package ate_pkg;

	localparam logic [3:0] MODE_INSERT   = 4'd0;
	localparam logic [3:0] MODE_APPEND   = 4'd1;
	localparam logic [3:0] MODE_DELETE   = 4'd2;
	localparam logic [3:0] MODE_GET      = 4'd3;
	localparam logic [3:0] MODE_SET      = 4'd4;
	localparam logic [3:0] MODE_SEARCH   = 4'd5;
	localparam logic [3:0] MODE_BSEARCH  = 4'd6;
	localparam logic [3:0] MODE_SINSERT  = 4'd7;
	localparam logic [3:0] MODE_MAX      = 4'd8;
	localparam logic [3:0] MODE_MIN      = 4'd9;
	localparam logic [3:0] MODE_SUM      = 4'd10;
	localparam logic [3:0] MODE_AVG      = 4'd11;
	localparam logic [3:0] MODE_SORTED   = 4'd12;
	localparam logic [3:0] MODE_REVERSE  = 4'd13;
	localparam logic [3:0] MODE_ROTATE   = 4'd14;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [4:0] {
		S_IDLE, S_START,
		S_UP_RD, S_UP_EX, S_ROT_EX,
		S_IDX_EX, S_DN_RD, S_DN_EX,
		S_SR_RD, S_SR_EX, S_SW_EX, S_SW_WR,
		S_BS_RD, S_BS_EX,
		S_SI_RD, S_SI_EX,
		S_MM_RD, S_MM_EX,
		S_SUM_RD, S_SUM_EX, S_DIV, S_DIV_END,
		S_SC_RD, S_SC_EX,
		S_RV_RD, S_RV_EX, S_RV_EX2, S_RV_WR,
		S_OUT
	} ate_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/array_table_engine_core.sv
// Top level of the array table engine: sequencer, word memory and result register.
// Items are handled one at a time; the next item is taken as the result appears.
// Reset: asynchronous, active low; clears the fill count and sets capacity to 1024.
`default_nettype none
module array_table_engine_core
	import ate_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // index [9:0], value [41:10], zero pad
	input  wire logic [3:0]  s_tuser,  // mode [3:0]
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // data [31:0], position [41:32], status [44:42], count [55:45]
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Address width of the memory and width of a count that can hold DEPTH.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// Widths used to compare the fixed 10-bit index and 11-bit capacity with counts.
	localparam int XW = (CW > 10) ? CW : 10;
	localparam int KW = (CW > 11) ? CW : 11;

	// Word memory: one write port and one registered read port.
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;
	logic [AW-1:0] raddr;

	ate_state_t    state_q, state_d;
	logic [10:0]   cap_q;
	logic [CW-1:0] n_q, n_d;
	logic          o_valid_q, o_valid_d;

	logic [3:0]    mode_q, mode_d;
	logic [9:0]    idx_q, idx_d;
	logic [31:0]   val_q, val_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW-1:0] tgt_q, tgt_d;
	logic [31:0]   acc_q, acc_d;
	logic [31:0]   data_q, data_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [2:0]    stat_q, stat_d;
	logic [31:0]   dq_q, dq_d;
	logic [CW-1:0] rem_q, rem_d;
	logic          dneg_q, dneg_d;
	logic [4:0]    cnt_q, cnt_d;
	logic [31:0]   o_data_q, o_data_d;
	logic [9:0]    o_pos_q, o_pos_d;
	logic [2:0]    o_stat_q, o_stat_d;
	logic [10:0]   o_cnt_q, o_cnt_d;

	logic [CW:0]   r2;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic [KW-1:0] lim;
	logic          full;
	logic [XW-1:0] idx_x, n_x;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = o_valid_q;
	assign m_tdata  = {o_cnt_q, o_stat_q, o_pos_q, o_data_q};
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_CAPACITY) ? {21'd0, cap_q} : 32'd0;

	// The limit in force is the smaller of the capacity register and DEPTH.
	assign lim   = (KW'(cap_q) < KW'(DEPTH)) ? KW'(cap_q) : KW'(DEPTH);
	assign full  = (KW'(n_q) >= lim);
	assign idx_x = XW'(idx_q);
	assign n_x   = XW'(n_q);

	// Binary search keeps an exclusive upper bound in j, so the probe is (lo + hi - 1) / 2.
	assign mid_sum = {1'b0, i_q} + {1'b0, j_q} - 1'b1;
	assign mid     = CW'(mid_sum >> 1);

	// Restoring divider: one quotient bit per cycle.
	assign r2 = {rem_q, dq_q[31]};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		o_valid_d = o_valid_q;
		mode_d    = mode_q;
		idx_d     = idx_q;
		val_d     = val_q;
		i_d       = i_q;
		j_d       = j_q;
		tgt_d     = tgt_q;
		acc_d     = acc_q;
		data_d    = data_q;
		pos_d     = pos_q;
		stat_d    = stat_q;
		dq_d      = dq_q;
		rem_d     = rem_q;
		dneg_d    = dneg_q;
		cnt_d     = cnt_q;
		o_data_d  = o_data_q;
		o_pos_d   = o_pos_q;
		o_stat_d  = o_stat_q;
		o_cnt_d   = o_cnt_q;
		we        = 1'b0;
		wa        = '0;
		wd        = val_q;
		raddr     = '0;

		if (o_valid_q && m_tready) begin
			o_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					mode_d  = s_tuser[3:0];
					idx_d   = s_tdata[9:0];
					val_d   = s_tdata[41:10];
					data_d  = '0;
					pos_d   = '0;
					stat_d  = ST_OK;
					state_d = S_START;
				end
			end
			S_START: begin
				state_d = S_OUT;
				case (mode_q)
					MODE_INSERT: begin
						if (full) begin
							stat_d = ST_FULL;
						end else if (idx_x > n_x) begin
							stat_d = ST_RANGE;
						end else begin
							i_d     = n_q;
							tgt_d   = CW'(idx_q);
							state_d = S_UP_RD;
						end
					end
					MODE_APPEND: begin
						if (full) begin
							stat_d = ST_FULL;
						end else begin
							we  = 1'b1;
							wa  = AW'(n_q);
							n_d = CW'(n_q + 1'b1);
						end
					end
					MODE_DELETE, MODE_GET, MODE_SET: begin
						if (n_q == '0) begin
							stat_d = ST_EMPTY;
						end else if (idx_x >= n_x) begin
							stat_d = ST_RANGE;
						end else if (mode_q == MODE_SET) begin
							we     = 1'b1;
							wa     = AW'(idx_q);
							data_d = val_q;
						end else begin
							raddr   = AW'(idx_q);
							state_d = S_IDX_EX;
						end
					end
					MODE_SEARCH: begin
						stat_d  = ST_NOTFOUND;
						i_d     = '0;
						state_d = S_SR_RD;
					end
					MODE_BSEARCH: begin
						stat_d  = ST_NOTFOUND;
						i_d     = '0;
						j_d     = n_q;
						state_d = S_BS_RD;
					end
					MODE_SINSERT: begin
						if (full) begin
							stat_d = ST_FULL;
						end else begin
							i_d     = n_q;
							state_d = S_SI_RD;
						end
					end
					MODE_MAX, MODE_MIN: begin
						if (n_q == '0) begin
							stat_d = ST_EMPTY;
						end else begin
							i_d     = '0;
							state_d = S_MM_RD;
						end
					end
					MODE_SUM, MODE_AVG: begin
						i_d     = '0;
						acc_d   = '0;
						state_d = S_SUM_RD;
					end
					MODE_SORTED: begin
						data_d  = 32'd1;
						i_d     = '0;
						state_d = S_SC_RD;
					end
					MODE_REVERSE: begin
						if (n_q > CW'(1)) begin
							i_d     = '0;
							j_d     = CW'(n_q - 1'b1);
							state_d = S_RV_RD;
						end
					end
					MODE_ROTATE: begin
						if (n_q > CW'(1)) begin
							raddr   = AW'(n_q - 1'b1);
							state_d = S_ROT_EX;
						end
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			// Shift words up by one from the top down to the target, then drop val in.
			S_UP_RD: begin
				if (i_q > tgt_q) begin
					raddr   = AW'(i_q - 1'b1);
					state_d = S_UP_EX;
				end else begin
					we = 1'b1;
					wa = AW'(tgt_q);
					if (mode_q == MODE_INSERT) begin
						n_d = CW'(n_q + 1'b1);
					end
					state_d = S_OUT;
				end
			end
			S_UP_EX: begin
				we      = 1'b1;
				wa      = AW'(i_q);
				wd      = rdata_q;
				i_d     = CW'(i_q - 1'b1);
				state_d = S_UP_RD;
			end
			S_ROT_EX: begin
				val_d   = rdata_q;
				tgt_d   = '0;
				i_d     = CW'(n_q - 1'b1);
				state_d = S_UP_RD;
			end
			S_IDX_EX: begin
				data_d = rdata_q;
				if (mode_q == MODE_DELETE) begin
					i_d     = CW'(idx_q);
					state_d = S_DN_RD;
				end else begin
					state_d = S_OUT;
				end
			end
			// Close the gap left by a delete.
			S_DN_RD: begin
				if (({1'b0, i_q} + 1'b1) < {1'b0, n_q}) begin
					raddr   = AW'(i_q + 1'b1);
					state_d = S_DN_EX;
				end else begin
					n_d     = CW'(n_q - 1'b1);
					state_d = S_OUT;
				end
			end
			S_DN_EX: begin
				we      = 1'b1;
				wa      = AW'(i_q);
				wd      = rdata_q;
				i_d     = CW'(i_q + 1'b1);
				state_d = S_DN_RD;
			end
			S_SR_RD: begin
				if (i_q < n_q) begin
					raddr   = AW'(i_q);
					state_d = S_SR_EX;
				end else begin
					state_d = S_OUT;
				end
			end
			S_SR_EX: begin
				if (rdata_q == val_q) begin
					pos_d   = i_q;
					stat_d  = ST_OK;
					raddr   = '0;
					state_d = S_SW_EX;
				end else begin
					i_d     = CW'(i_q + 1'b1);
					state_d = S_SR_RD;
				end
			end
			// Move to front: the hit slot takes word 0, and word 0 takes the key.
			S_SW_EX: begin
				we      = 1'b1;
				wa      = AW'(i_q);
				wd      = rdata_q;
				state_d = S_SW_WR;
			end
			S_SW_WR: begin
				we      = 1'b1;
				wa      = '0;
				state_d = S_OUT;
			end
			S_BS_RD: begin
				if (i_q < j_q) begin
					raddr   = AW'(mid);
					tgt_d   = mid;
					state_d = S_BS_EX;
				end else begin
					state_d = S_OUT;
				end
			end
			S_BS_EX: begin
				if (rdata_q == val_q) begin
					pos_d   = tgt_q;
					stat_d  = ST_OK;
					state_d = S_OUT;
				end else begin
					if ($signed(val_q) < $signed(rdata_q)) begin
						j_d = tgt_q;
					end else begin
						i_d = CW'(tgt_q + 1'b1);
					end
					state_d = S_BS_RD;
				end
			end
			S_SI_RD: begin
				if (i_q != '0) begin
					raddr   = AW'(i_q - 1'b1);
					state_d = S_SI_EX;
				end else begin
					we      = 1'b1;
					wa      = '0;
					pos_d   = '0;
					n_d     = CW'(n_q + 1'b1);
					state_d = S_OUT;
				end
			end
			S_SI_EX: begin
				we = 1'b1;
				wa = AW'(i_q);
				if ($signed(rdata_q) > $signed(val_q)) begin
					wd      = rdata_q;
					i_d     = CW'(i_q - 1'b1);
					state_d = S_SI_RD;
				end else begin
					pos_d   = i_q;
					n_d     = CW'(n_q + 1'b1);
					state_d = S_OUT;
				end
			end
			S_MM_RD: begin
				if (i_q < n_q) begin
					raddr   = AW'(i_q);
					state_d = S_MM_EX;
				end else begin
					data_d  = acc_q;
					state_d = S_OUT;
				end
			end
			S_MM_EX: begin
				if ((i_q == '0) ||
				    ((mode_q == MODE_MAX) && ($signed(rdata_q) > $signed(acc_q))) ||
				    ((mode_q == MODE_MIN) && ($signed(rdata_q) < $signed(acc_q)))) begin
					acc_d = rdata_q;
				end
				i_d     = CW'(i_q + 1'b1);
				state_d = S_MM_RD;
			end
			S_SUM_RD: begin
				if (i_q < n_q) begin
					raddr   = AW'(i_q);
					state_d = S_SUM_EX;
				end else if (mode_q == MODE_SUM) begin
					data_d  = acc_q;
					state_d = S_OUT;
				end else if (n_q == '0) begin
					stat_d  = ST_EMPTY;
					state_d = S_OUT;
				end else begin
					dneg_d  = acc_q[31];
					dq_d    = acc_q[31] ? (32'd0 - acc_q) : acc_q;
					rem_d   = '0;
					cnt_d   = '0;
					state_d = S_DIV;
				end
			end
			S_SUM_EX: begin
				acc_d   = acc_q + rdata_q;
				i_d     = CW'(i_q + 1'b1);
				state_d = S_SUM_RD;
			end
			S_DIV: begin
				if (r2 >= {1'b0, n_q}) begin
					rem_d = CW'(r2 - {1'b0, n_q});
					dq_d  = {dq_q[30:0], 1'b1};
				end else begin
					rem_d = CW'(r2);
					dq_d  = {dq_q[30:0], 1'b0};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				data_d  = dneg_q ? (32'd0 - dq_q) : dq_q;
				state_d = S_OUT;
			end
			S_SC_RD: begin
				if (i_q < n_q) begin
					raddr   = AW'(i_q);
					state_d = S_SC_EX;
				end else begin
					state_d = S_OUT;
				end
			end
			S_SC_EX: begin
				if ((i_q != '0) && ($signed(acc_q) > $signed(rdata_q))) begin
					data_d  = '0;
					state_d = S_OUT;
				end else begin
					acc_d   = rdata_q;
					i_d     = CW'(i_q + 1'b1);
					state_d = S_SC_RD;
				end
			end
			// Reverse: read both ends, then write them back crossed.
			S_RV_RD: begin
				if (i_q < j_q) begin
					raddr   = AW'(i_q);
					state_d = S_RV_EX;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RV_EX: begin
				acc_d   = rdata_q;
				raddr   = AW'(j_q);
				state_d = S_RV_EX2;
			end
			S_RV_EX2: begin
				we      = 1'b1;
				wa      = AW'(i_q);
				wd      = rdata_q;
				state_d = S_RV_WR;
			end
			S_RV_WR: begin
				we      = 1'b1;
				wa      = AW'(j_q);
				wd      = acc_q;
				i_d     = CW'(i_q + 1'b1);
				j_d     = CW'(j_q - 1'b1);
				state_d = S_RV_RD;
			end
			// The result waits here only while the output register is still occupied.
			S_OUT: begin
				if (!o_valid_q || m_tready) begin
					o_valid_d = 1'b1;
					o_data_d  = data_q;
					o_pos_d   = 10'(pos_q);
					o_stat_d  = stat_q;
					o_cnt_d   = 11'(n_q);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			o_valid_q <= 1'b0;
			cap_q     <= 11'd1024;
		end else begin
			state_q   <= state_d;
			n_q       <= n_d;
			o_valid_q <= o_valid_d;
			if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
				cap_q <= pwdata[10:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q   <= mode_d;
		idx_q    <= idx_d;
		val_q    <= val_d;
		i_q      <= i_d;
		j_q      <= j_d;
		tgt_q    <= tgt_d;
		acc_q    <= acc_d;
		data_q   <= data_d;
		pos_q    <= pos_d;
		stat_q   <= stat_d;
		dq_q     <= dq_d;
		rem_q    <= rem_d;
		dneg_q   <= dneg_d;
		cnt_q    <= cnt_d;
		o_data_q <= o_data_d;
		o_pos_q  <= o_pos_d;
		o_stat_q <= o_stat_d;
		o_cnt_q  <= o_cnt_d;
	end

endmodule
`default_nettype wire

>>> hw/rtl/ate_checker.sv
// Port-level checks for the array table engine, bound to the top level.
`default_nettype none
module ate_checker
	import ate_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata
);

	// An accepted item keeps the engine busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted item");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Status codes stay within the defined set.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[44:42] <= ST_EMPTY))
		else $error("undefined status code");

	// The reported fill count never exceeds the array depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[55:45]) <= 32'(DEPTH)))
		else $error("fill count above depth");

endmodule

bind array_table_engine_core ate_checker #(.DEPTH(DEPTH)) u_ate_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
